// File: rtl/core/pvrc_pkg.sv
// Shared types and constants for the PIN verify / retry counter block.
// Holds command and status codes, payload structs and the front-to-back record.
// No dependencies.
package pvrc_pkg;

  localparam int unsigned PIN_LEN_W = 7;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned SW_W      = 15;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SW_W-1:0] SW_BASE = 15'h63C0;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PIN_LEN = 2'd1;

  typedef enum logic [2:0] {
    CMD_VERIFY      = 3'd0,
    CMD_CREATE      = 3'd1,
    CMD_UPDATE      = 3'd2,
    CMD_CLEAR       = 3'd3,
    CMD_SET_RETRIES = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LEN_INVALID = 2'd1,
    ST_AUTH_FAILED = 2'd2,
    ST_NO_PIN      = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] pin_byte;
    logic       byte_valid;
    logic       byte_last;
    logic [7:0] retry_limit;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic                validated;
    logic [RETRY_W-1:0]  retries_left;
    logic [SW_W-1:0]     status_word;
  } out_item_t;

  // One classified item as the front hands it to the back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] pin_byte;
    logic       kept;       // byte goes into the PIN buffers
    logic       last;
    logic       overflow;   // run has dropped a byte so far
    logic [7:0] retry_limit;
  } front_rec_t;

endpackage

// File: rtl/core/pvrc_ram.sv
// One PIN byte bank: single write port, single registered read port.
// A read of the address written in the same cycle returns the new byte.
// Uses no package.
module pvrc_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/pvrc_front.sv
// Front end: accepts input items, counts PIN bytes of the current run and
// marks dropped (overlong) bytes. Depends on pvrc_pkg.
module pvrc_front import pvrc_pkg::*; #(
  parameter int unsigned MAX_PIN_BYTES = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  in_item_t                             in_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output front_rec_t                           push_rec_o,
  output logic [$clog2(MAX_PIN_BYTES+1)-1:0]   push_len_o
);

  localparam int unsigned CW = $clog2(MAX_PIN_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIN_BYTES);

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          kept;
  logic          accept;

  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  assign kept    = in_i.byte_valid && (count_q < MAX_CNT);
  assign count_d = count_q + CW'(kept);
  assign ovf_d   = ovf_q || (in_i.byte_valid && !kept);

  always_comb begin
    push_rec_o.cmd         = in_i.cmd;
    push_rec_o.pin_byte    = in_i.pin_byte;
    push_rec_o.kept        = kept;
    push_rec_o.last        = in_i.byte_last;
    push_rec_o.overflow    = ovf_d;
    push_rec_o.retry_limit = in_i.retry_limit;
    push_len_o             = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      // restart the byte count after the item that ends a command
      if (in_i.byte_last) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// File: rtl/core/pvrc_queue.sv
// Two-entry queue between the front end and the back end.
// Generic width; uses no package.
module pvrc_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/pvrc_back.sv
// Back end: reads the stored PIN byte, compares, stages the new byte and runs
// the command on the last item of a run. Two banks swap roles on commit.
// Depends on pvrc_pkg and pvrc_ram.
module pvrc_back import pvrc_pkg::*; #(
  parameter int unsigned MAX_PIN_BYTES = 64,
  parameter int unsigned RETRY_CAP     = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  front_rec_t                         pop_rec_i,
  input  logic [$clog2(MAX_PIN_BYTES+1)-1:0] pop_len_i,
  input  logic [PIN_LEN_W-1:0]               min_len_i,
  input  logic [PIN_LEN_W-1:0]               max_len_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output out_item_t                          out_o
);

  localparam int unsigned CW = $clog2(MAX_PIN_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_PIN_BYTES);
  localparam int unsigned LW = (CW > PIN_LEN_W) ? CW : PIN_LEN_W;
  localparam logic [RETRY_W-1:0] MAX_RL = RETRY_W'(RETRY_CAP);
  localparam logic [7:0]         MAX_LIMIT = 8'(RETRY_CAP);

  // compare stage
  logic          b_vld_q;
  front_rec_t    b_rec_q;
  logic [CW-1:0] b_len_q;
  logic [AW-1:0] b_idx, rd_idx;
  logic          b_fire, pop, out_free;

  // command state
  logic [CW-1:0]      stored_len_q, stored_len_d;
  logic               present_q, present_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [RETRY_W-1:0] default_q, default_d;
  logic               validated_q, validated_d;
  logic               stored_bank_q, stored_bank_d;
  logic               miss_q;

  logic [7:0]         rd0, rd1, stored_byte;
  logic               byte_miss, miss_all;
  logic               len_bad, limit_bad;
  status_e            status;
  logic [RETRY_W-1:0] rl, cur_cnt, rl_out, rl_clamp;
  logic               use_cur;
  logic               out_valid_q;
  out_item_t          out_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign b_fire      = b_vld_q && (!b_rec_q.last || out_free);
  assign pop_ready_o = !b_vld_q || b_fire;
  assign pop         = pop_valid_i && pop_ready_o;

  assign rd_idx = AW'(pop_len_i - CW'(1));
  assign b_idx  = AW'(b_len_q - CW'(1));

  // staging bank is the one not holding the stored PIN
  pvrc_ram #(.DEPTH(MAX_PIN_BYTES)) u_bank0 (
    .clk_i     (clk_i),
    .rd_en_i   (pop),
    .rd_addr_i (rd_idx),
    .rd_data_o (rd0),
    .wr_en_i   (b_fire && b_rec_q.kept && stored_bank_q),
    .wr_addr_i (b_idx),
    .wr_data_i (b_rec_q.pin_byte)
  );

  pvrc_ram #(.DEPTH(MAX_PIN_BYTES)) u_bank1 (
    .clk_i     (clk_i),
    .rd_en_i   (pop),
    .rd_addr_i (rd_idx),
    .rd_data_o (rd1),
    .wr_en_i   (b_fire && b_rec_q.kept && !stored_bank_q),
    .wr_addr_i (b_idx),
    .wr_data_i (b_rec_q.pin_byte)
  );

  assign stored_byte = stored_bank_q ? rd1 : rd0;
  // index at or past the stored length counts as a mismatch
  assign byte_miss = b_rec_q.kept &&
                     ((b_len_q > stored_len_q) || (stored_byte != b_rec_q.pin_byte));
  assign miss_all  = miss_q || byte_miss;

  assign len_bad   = b_rec_q.overflow || (LW'(b_len_q) < LW'(min_len_i)) ||
                     (LW'(b_len_q) > LW'(max_len_i));
  assign limit_bad = (b_rec_q.retry_limit == 8'd0) || (b_rec_q.retry_limit > MAX_LIMIT);

  always_comb begin
    stored_len_d  = stored_len_q;
    present_d     = present_q;
    retry_d       = retry_q;
    default_d     = default_q;
    validated_d   = validated_q;
    stored_bank_d = stored_bank_q;
    status        = ST_OK;
    rl            = '0;
    use_cur       = 1'b1;
    case (b_rec_q.cmd)
      CMD_VERIFY: begin
        validated_d = 1'b0;
        if (len_bad) begin
          status = ST_LEN_INVALID;
        end else if (!present_q) begin
          status  = ST_NO_PIN;
          use_cur = 1'b0;
        end else if (retry_q == '0) begin
          status  = ST_AUTH_FAILED;
          use_cur = 1'b0;
        end else if (miss_all || (b_len_q != stored_len_q)) begin
          retry_d = retry_q - RETRY_W'(1);
          status  = ST_AUTH_FAILED;
          rl      = retry_d;
          use_cur = 1'b0;
        end else begin
          rl          = retry_q;
          use_cur     = 1'b0;
          retry_d     = default_q;
          validated_d = 1'b1;
        end
      end
      CMD_CREATE: begin
        if (limit_bad || b_rec_q.overflow) begin
          status = ST_LEN_INVALID;
        end else begin
          stored_bank_d = ~stored_bank_q;
          stored_len_d  = b_len_q;
          present_d     = 1'b1;
          retry_d       = RETRY_W'(b_rec_q.retry_limit);
          default_d     = RETRY_W'(b_rec_q.retry_limit);
        end
      end
      CMD_UPDATE: begin
        if (len_bad) begin
          status = ST_LEN_INVALID;
        end else begin
          validated_d = 1'b0;
          if (!present_q) begin
            status = ST_NO_PIN;
          end else begin
            stored_bank_d = ~stored_bank_q;
            stored_len_d  = b_len_q;
            retry_d       = default_q;
          end
        end
      end
      CMD_CLEAR: begin
        if (!present_q) begin
          status = ST_NO_PIN;
        end else begin
          stored_len_d = '0;
          retry_d      = default_q;
        end
      end
      CMD_SET_RETRIES: begin
        if (limit_bad) begin
          status = ST_LEN_INVALID;
        end else if (!present_q) begin
          status = ST_NO_PIN;
        end else begin
          retry_d   = RETRY_W'(b_rec_q.retry_limit);
          default_d = RETRY_W'(b_rec_q.retry_limit);
        end
      end
      default: begin
        status = ST_LEN_INVALID;
      end
    endcase
    cur_cnt  = (present_d && (stored_len_d != '0)) ? retry_d : '0;
    rl_out   = use_cur ? cur_cnt : rl;
    rl_clamp = (rl_out > MAX_RL) ? MAX_RL : rl_out;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_rec_q <= pop_rec_i;
      b_len_q <= pop_len_i;
    end
    if (b_fire && b_rec_q.last) begin
      out_q.status       <= status;
      out_q.validated    <= validated_d;
      out_q.retries_left <= rl_out;
      out_q.status_word  <= SW_BASE + SW_W'(rl_clamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q       <= 1'b0;
      miss_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      stored_len_q  <= '0;
      present_q     <= 1'b0;
      retry_q       <= '0;
      default_q     <= '0;
      validated_q   <= 1'b0;
      stored_bank_q <= 1'b0;
    end else begin
      if (pop) begin
        b_vld_q <= 1'b1;
      end else if (b_fire) begin
        b_vld_q <= 1'b0;
      end
      if (b_fire) begin
        miss_q <= b_rec_q.last ? 1'b0 : miss_all;
      end
      if (b_fire && b_rec_q.last) begin
        out_valid_q   <= 1'b1;
        stored_len_q  <= stored_len_d;
        present_q     <= present_d;
        retry_q       <= retry_d;
        default_q     <= default_d;
        validated_q   <= validated_d;
        stored_bank_q <= stored_bank_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/pin_verify_retry_counter_top.sv
// PIN store with retry counter: input item channel, result channel and a
// register write port for the PIN length limits.
// A command is a run of input items, one PIN byte each, ended by byte_last.
// Only the last item of a run yields a result. The block accepts one item
// per cycle, every cycle, as long as the front queue has room; the compare
// stage reads one byte of the stored PIN per item from a memory bank, which
// sets that rate.
// The last item of a run passes through the queue and the compare stage
// register before its result is registered and drives out_valid_o.
// If the receiver stalls, the result is held in the output register; the
// compare stage and a two-entry queue keep taking items until that stage
// holds the next last item; in_ready_o drops once the queue is full.
// Reset clears the counters, the validated flag and the PIN-present flag and
// sets the length limits to 0 and 64. The PIN memories are not cleared; a
// byte is never compared beyond the stored length, so none is needed.
// Configuration writes are always ready; limits are checked at each run's last item.
// Depends on pvrc_pkg, pvrc_front, pvrc_queue and pvrc_back.
module pin_verify_retry_counter_top import pvrc_pkg::*; #(
  parameter int unsigned MAX_PIN_BYTES = 64,
  parameter int unsigned RETRY_CAP     = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PIN_LEN_W-1:0] cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_PIN_BYTES + 1);
  localparam int unsigned REC_W = $bits(front_rec_t);
  localparam int unsigned Q_W   = REC_W + CW;

  logic [PIN_LEN_W-1:0] min_len_q, max_len_q;

  logic          f_valid, f_ready;
  front_rec_t    f_rec;
  logic [CW-1:0] f_len;
  logic          q_valid, q_ready;
  logic [Q_W-1:0] q_data;
  front_rec_t    q_rec;
  logic [CW-1:0] q_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= PIN_LEN_W'(0);
      max_len_q <= PIN_LEN_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        REG_MIN_PIN_LEN: min_len_q <= cfg_data_i;
        REG_MAX_PIN_LEN: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pvrc_front #(.MAX_PIN_BYTES(MAX_PIN_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_rec_o   (f_rec),
    .push_len_o   (f_len)
  );

  pvrc_queue #(.WIDTH(Q_W)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_len, f_rec}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_rec = front_rec_t'(q_data[REC_W-1:0]);
  assign q_len = q_data[Q_W-1:REC_W];

  pvrc_back #(
    .MAX_PIN_BYTES (MAX_PIN_BYTES),
    .RETRY_CAP     (RETRY_CAP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .pop_rec_i   (q_rec),
    .pop_len_i   (q_len),
    .min_len_i   (min_len_q),
    .max_len_i   (max_len_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
